// ===== hdl/iost_pkg.sv =====
// Shared types and constants for the insertion-ordered set table.
// Has no dependencies. Every other file in this block uses it.
package iost_pkg;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 32;
	localparam int MCOUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} opcode_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take the incoming word into the operand registers
		logic exec;      // update the table and load the result register
	} iost_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // result register is empty or being drained this cycle
	} iost_status_t;

endpackage

// ===== hdl/iost_if.sv =====
// Valid/ready channel interfaces for the insertion-ordered set table.
// Depends on iost_pkg for field widths.
interface iost_in_if;
	logic                                valid;
	logic                                ready;
	logic [iost_pkg::OP_W-1:0]           opcode;
	logic signed [iost_pkg::VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface iost_out_if;
	logic                               valid;
	logic                               ready;
	logic                               success;
	logic [iost_pkg::MCOUNT_W-1:0]      member_count;
	logic                               set_empty;

	modport source (output valid, output success, output member_count, output set_empty,
		input ready);
	modport sink   (input valid, input success, input member_count, input set_empty,
		output ready);
endinterface

// ===== hdl/iost_ctrl.sv =====
// Sequencer for the insertion-ordered set table: accept, compare, execute.
// Depends on iost_pkg for the command and status structs.
module iost_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  iost_pkg::iost_status_t status,
	output iost_pkg::iost_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold until the result register can take the word
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/iost_dp.sv =====
// Datapath of the insertion-ordered set table: entry registers, count,
// parallel compare, compaction shift and result register. Depends on iost_pkg.
module iost_dp #(
	parameter int SET_CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iost_pkg::iost_cmd_t                 cmd,
	input  logic [iost_pkg::OP_W-1:0]           opcode,
	input  logic signed [iost_pkg::VALUE_W-1:0] value,
	output iost_pkg::iost_status_t              status,
	iost_out_if.source                          rsp
);

	localparam int CW = $clog2(SET_CAPACITY + 1);
	localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

	logic [iost_pkg::VALUE_W-1:0] entries_q [SET_CAPACITY];
	logic [CW-1:0]                count_q;
	logic [iost_pkg::OP_W-1:0]    op_q;
	logic [iost_pkg::VALUE_W-1:0] value_q;
	logic                         found_q;
	logic [IW-1:0]                slot_q;

	logic [SET_CAPACITY-1:0]      hit;
	logic [IW-1:0]                slot_d;
	logic                         full;
	logic                         ok;
	logic [CW-1:0]                count_d;

	logic                         out_valid_q;
	logic                         success_q;
	logic [iost_pkg::MCOUNT_W-1:0] member_count_q;
	logic                         set_empty_q;

	// compare every used slot at once; values are distinct so at most one hits
	always_comb begin
		slot_d = '0;
		for (int i = 0; i < SET_CAPACITY; i++) begin
			hit[i] = (CW'(i) < count_q) && (entries_q[i] == value_q);
			if (hit[i]) begin
				slot_d = slot_d | IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			value_q <= value;
		end
		found_q <= |hit;
		slot_q  <= slot_d;
	end

	assign full = (count_q == CW'(SET_CAPACITY));

	always_comb begin
		ok      = 1'b0;
		count_d = count_q;
		case (op_q)
			iost_pkg::OP_ADD: begin
				ok = !found_q && !full;
				if (ok) begin
					count_d = count_q + CW'(1);
				end
			end
			iost_pkg::OP_REMOVE: begin
				ok = found_q;
				if (ok) begin
					count_d = count_q - CW'(1);
				end
			end
			iost_pkg::OP_CONTAINS: begin
				ok = found_q;
			end
			default: begin
				ok      = 1'b1;
				count_d = '0;
			end
		endcase
	end

	// append at the tail, or close the gap left by a removed entry
	always_ff @(posedge clk) begin
		if (cmd.exec && ok) begin
			if (op_q == iost_pkg::OP_ADD) begin
				for (int j = 0; j < SET_CAPACITY; j++) begin
					if (count_q == CW'(j)) begin
						entries_q[j] <= value_q;
					end
				end
			end else if (op_q == iost_pkg::OP_REMOVE) begin
				for (int j = 0; j < SET_CAPACITY - 1; j++) begin
					if (IW'(j) >= slot_q) begin
						entries_q[j] <= entries_q[j+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			success_q      <= ok;
			member_count_q <= iost_pkg::MCOUNT_W'(count_d);
			set_empty_q    <= (count_d == '0);
		end
	end

	assign status.out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.success      = success_q;
	assign rsp.member_count = member_count_q;
	assign rsp.set_empty    = set_empty_q;

endmodule

// ===== hdl/insertion_ordered_set_table.sv =====
// Insertion-ordered set table: holds up to SET_CAPACITY distinct signed 32-bit
// values packed in the order they were added, and answers every add, remove,
// contains or clear word with one result word (success, member count, empty).
// The accepting edge latches the operands, the compare state checks every used
// entry at once and registers the hit, and the execute state updates the table
// and loads the result register, holding while that register cannot take the
// word. A new word is taken once the previous one has been executed, while its
// result may still wait in the output register; the next result waits only if
// that register is still full.
// With more than 31 entries member_count carries the low five bits of the count.
// Depends on iost_pkg, iost_if, iost_ctrl and iost_dp.
module insertion_ordered_set_table #(
	parameter int SET_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	iost_in_if.sink     req,
	iost_out_if.source  rsp
);

	iost_pkg::iost_cmd_t    cmd;
	iost_pkg::iost_status_t status;
	logic                   in_ready;

	iost_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	iost_dp #(
		.SET_CAPACITY (SET_CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opcode (req.opcode),
		.value  (req.value),
		.status (status),
		.rsp    (rsp)
	);

	assign req.ready = in_ready;

endmodule
